### hdl/gps_carrier_code_tracking_loop_core_defines.svh
// Assertion macros shared by the tracking loop core.
`ifndef GPS_CARRIER_CODE_TRACKING_LOOP_CORE_DEFINES_SVH
`define GPS_CARRIER_CODE_TRACKING_LOOP_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define GCCTL_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GCCTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/gcctl_pkg.sv
// Types, constants and helpers shared by the tracking loop core.
`default_nettype none
package gcctl_pkg;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  localparam logic [2:0] REG_ACQUIRE_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_LOSS_THRESHOLD      = 3'd1;
  localparam logic [2:0] REG_PULL_IN_LIMIT       = 3'd2;
  localparam logic [2:0] REG_SEARCH_WIDTH        = 3'd3;
  localparam logic [2:0] REG_CODE_REFERENCE      = 3'd4;
  localparam logic [2:0] REG_CARRIER_REFERENCE   = 3'd5;
  localparam logic [2:0] REG_CODE_SEARCH_STEP    = 3'd6;
  localparam logic [2:0] REG_CARRIER_SEARCH_STEP = 3'd7;

  localparam int unsigned LK_CODE  = 0;
  localparam int unsigned LK_CARR  = 1;
  localparam int unsigned LK_PHASE = 2;

  localparam logic [2:0] LOCK_NONE  = 3'b000;
  localparam logic [2:0] LOCK_CODE  = 3'b001;
  localparam logic [2:0] LOCK_CARR  = 3'b011;
  localparam logic [2:0] LOCK_PHASE = 3'b111;

  typedef struct packed {
    logic              action;
    logic [3:0]        channel;
    logic signed [15:0] prompt_i;
    logic signed [15:0] prompt_q;
    logic signed [15:0] early_i;
    logic signed [15:0] early_q;
    logic signed [15:0] late_i;
    logic signed [15:0] late_q;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic [31:0]        carrier_word;
    logic [31:0]        code_word;
    logic               code_locked;
    logic               carrier_locked;
    logic               phase_locked;
    logic               slew_request;
    logic               released;
    logic signed [31:0] average_code_power;
  } out_item_t;

  typedef struct packed {
    logic [31:0] acquire_threshold;
    logic [31:0] loss_threshold;
    logic [11:0] pull_in_limit;
    logic [4:0]  search_width;
    logic [31:0] code_reference;
    logic [31:0] carrier_reference;
    logic [15:0] code_search_step;
    logic [15:0] carrier_search_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         lock_bits;
    logic [31:0]        code_power_avg;
    logic [31:0]        carrier_power_avg;
    logic [31:0]        carrier_nco_word;
    logic [31:0]        code_nco_word;
    logic signed [13:0] previous_i_prompt;
    logic signed [13:0] previous_q_prompt;
    logic [31:0]        previous_phase_error;
    logic [31:0]        previous_delay_error;
    logic [11:0]        pull_in_count;
    logic [10:0]        half_chip_count;
    logic [4:0]         frequency_bin;
  } chan_state_t;

  localparam cfg_t CFG_RESET = '{
    acquire_threshold:   32'd53600,
    loss_threshold:      32'd26800,
    pull_in_limit:       12'd3000,
    search_width:        5'd20,
    code_reference:      32'd13730473,
    carrier_reference:   32'd32480690,
    code_search_step:    16'd4,
    carrier_search_step: 16'd6711
  };

  function automatic chan_state_t init_state(input cfg_t c);
    chan_state_t s;
    s = '0;
    s.code_power_avg    = c.loss_threshold;
    s.carrier_power_avg = c.loss_threshold;
    s.carrier_nco_word  = c.carrier_reference;
    s.code_nco_word     = c.code_reference;
    return s;
  endfunction

endpackage
`default_nettype wire

### hdl/gcctl_state_mem.sv
// Per-channel state memory with registered read and written-entry flags.
`default_nettype none
module gcctl_state_mem #(
  parameter int NUM_CHANNELS = 16,
  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  output gcctl_pkg::chan_state_t      rd_data,
  input  wire logic                   wr_en,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  gcctl_pkg::chan_state_t      wr_data
);
  import gcctl_pkg::*;

  chan_state_t             mem [NUM_CHANNELS];
  chan_state_t             rd_q;
  logic [NUM_CHANNELS-1:0] written;
  logic                    rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // An entry never written since reset holds the power-on channel state.
  assign rd_data = rd_written ? rd_q : init_state(CFG_RESET);

endmodule
`default_nettype wire

### hdl/gcctl_loop.sv
// Four-stage read-modify-write pipeline for the PLL/FLL, DLL and search.
`default_nettype none
module gcctl_loop #(
  parameter int NUM_CHANNELS     = 16,
  parameter int CODE_SEARCH_SPAN = 2045,
  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  gcctl_pkg::in_item_t        item,
  input  gcctl_pkg::cfg_t            cfg,
  input  gcctl_pkg::chan_state_t     rd_data,
  input  wire logic [3:0]            probe_channel,
  output logic                       conflict,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output gcctl_pkg::chan_state_t     wr_data,
  output logic                       res_valid,
  output gcctl_pkg::out_item_t       res
);
  import gcctl_pkg::*;

  typedef struct packed {
    logic               action;
    logic [3:0]         chan;
    chan_state_t        st;
    logic signed [13:0] ip;
    logic signed [13:0] qp;
    logic [31:0]        pc;
    logic [31:0]        pk;
    logic [31:0]        f;
    logic [31:0]        x;
    logic [4:0]         bn;
    logic               rel;
    logic               over;
    logic [10:0]        h;
    logic [31:0]        code_off;
    logic [31:0]        carr_off;
    logic               pd_zero;
    logic               pp_zero;
    logic [31:0]        e;
    logic [31:0]        tau;
    logic [31:0]        ae;
    logic [31:0]        at;
    logic [31:0]        af;
  } pipe_t;

  in_item_t r1;
  pipe_t    c1, r2, c2, r3, c3, r4;
  logic     v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r1 <= item;
    end
    r2 <= c1;
    r3 <= c2;
    r4 <= c3;
  end

  // A channel already in flight must be written back before it is read again.
  assign conflict = (v1 && r1.channel == probe_channel) || (v2 && r2.chan == probe_channel) ||
                    (v3 && r3.chan == probe_channel) || (v4 && r4.chan == probe_channel);

  // Stage 1: scale the sums, form all products and prepare the next search bin.
  logic signed [13:0] ip, qp, ie, qe, il, ql;
  logic signed [14:0] de, dq;
  logic signed [31:0] sq_i, sq_q, m_pi, m_qq, m_qi, m_iq, m_de, m_dq;
  logic signed [31:0] code_off, carr_off;
  logic [5:0]         b6, bn6;
  logic signed [5:0]  fb;
  logic               rel;
  logic [11:0]        h12;

  assign ip = $signed(r1.prompt_i[15:2]);
  assign qp = $signed(r1.prompt_q[15:2]);
  assign ie = $signed(r1.early_i[15:2]);
  assign qe = $signed(r1.early_q[15:2]);
  assign il = $signed(r1.late_i[15:2]);
  assign ql = $signed(r1.late_q[15:2]);
  assign de = 15'(ie) - 15'(il);
  assign dq = 15'(qe) - 15'(ql);

  assign sq_i = 32'(ip) * 32'(ip);
  assign sq_q = 32'(qp) * 32'(qp);
  assign m_pi = 32'(ip) * 32'(rd_data.previous_i_prompt);
  assign m_qq = 32'(qp) * 32'(rd_data.previous_q_prompt);
  assign m_qi = 32'(qp) * 32'(rd_data.previous_i_prompt);
  assign m_iq = 32'(ip) * 32'(rd_data.previous_q_prompt);
  assign m_de = 32'(de) * 32'(ip);
  assign m_dq = 32'(dq) * 32'(qp);

  assign b6  = {1'b0, rd_data.frequency_bin} + 6'd1;
  assign rel = b6 > {1'b0, cfg.search_width};
  assign bn6 = rel ? 6'd0 : b6;
  // Odd bins step up, even bins step down: 0, +1, -1, +2, -2 ...
  assign fb  = bn6[0] ? $signed(6'({1'b0, bn6[5:1]}) + 6'd1)
                      : $signed(6'd0 - 6'({1'b0, bn6[5:1]}));
  assign code_off = 32'($signed({1'b0, cfg.code_search_step})) * 32'(fb);
  assign carr_off = 32'($signed({1'b0, cfg.carrier_search_step})) * 32'(fb);
  assign h12 = {1'b0, rd_data.half_chip_count} + 12'd1;

  always_comb begin
    c1          = '0;
    c1.action   = r1.action;
    c1.chan     = r1.channel;
    c1.st       = rd_data;
    c1.ip       = ip;
    c1.qp       = qp;
    c1.pc       = sq_i + sq_q;
    c1.pk       = m_pi + m_qq;
    c1.f        = m_qi - m_iq;
    c1.x        = m_de + m_dq;
    c1.bn       = bn6[4:0];
    c1.rel      = rel;
    c1.over     = {20'd0, h12} > 32'(CODE_SEARCH_SPAN);
    c1.h        = h12[10:0];
    c1.code_off = code_off;
    c1.carr_off = carr_off;
  end

  // Stage 2: power averages and the code lock decision.
  always_comb begin
    logic [31:0] dc, dk, ac, ak;
    logic        low;
    c2  = r2;
    dc  = r2.pc - r2.st.code_power_avg + 32'd128;
    dk  = r2.pk - r2.st.carrier_power_avg + 32'd128;
    ac  = $signed(dc) >>> 8;
    ak  = $signed(dk) >>> 8;
    if (r2.st.lock_bits[LK_CODE]) begin
      c2.st.code_power_avg    = r2.st.code_power_avg + ac;
      c2.st.carrier_power_avg = r2.st.carrier_power_avg + ak;
    end
    low = $signed({c2.st.code_power_avg[31], c2.st.code_power_avg}) <
          $signed({1'b0, cfg.loss_threshold});
    if (r2.pc > cfg.acquire_threshold && !r2.st.lock_bits[LK_CODE]) begin
      c2.st.lock_bits         = LOCK_CODE;
      c2.st.code_power_avg    = cfg.loss_threshold;
      c2.st.carrier_power_avg = cfg.loss_threshold;
      c2.pd_zero              = 1'b1;
    end else if (low) begin
      c2.st.lock_bits = LOCK_NONE;
    end
  end

  // Stage 3: carrier and phase lock, pull-in count, discriminator terms.
  always_comb begin
    logic signed [32:0] cp;
    logic signed [31:0] ipx;
    logic [31:0]        e, tau, te, tt, tf;
    c3  = r3;
    cp  = $signed({r3.st.carrier_power_avg[31], r3.st.carrier_power_avg});
    ipx = r3.ip;
    if (r3.st.lock_bits[LK_CODE]) begin
      if (cp > $signed({1'b0, cfg.acquire_threshold}) && !r3.st.lock_bits[LK_CARR]) begin
        c3.st.lock_bits     = LOCK_CARR;
        c3.st.pull_in_count = '0;
      end else if (cp < $signed({1'b0, cfg.loss_threshold})) begin
        c3.st.lock_bits = LOCK_CODE;
      end
    end
    if (c3.st.lock_bits[LK_CARR] && !c3.st.lock_bits[LK_PHASE]) begin
      c3.st.pull_in_count = c3.st.pull_in_count + 12'd1;
      if (c3.st.pull_in_count > cfg.pull_in_limit) begin
        c3.st.lock_bits = LOCK_PHASE;
        c3.pp_zero      = 1'b1;
      end
    end
    // Phase error is -sign(Q) * I.
    if (r3.qp > 14'sd0) begin
      e = 32'(-ipx) << 11;
    end else if (r3.qp < 14'sd0) begin
      e = 32'(ipx) << 11;
    end else begin
      e = '0;
    end
    tau    = r3.x << 7;
    te     = e + 32'd16;
    tt     = tau + 32'd256;
    tf     = r3.f + 32'd8192;
    c3.e   = e;
    c3.tau = tau;
    c3.ae  = $signed(te) >>> 5;
    c3.at  = $signed(tt) >>> 9;
    c3.af  = $signed(tf) >>> 14;
  end

  // Stage 4: restart, loop filters or search step, then write-back and result.
  always_comb begin
    chan_state_t s;
    logic [31:0] pphase, pdelay, d, dd, td, tdd, sd, sdd;
    logic        slew, released;
    s        = r4.st;
    slew     = 1'b0;
    released = 1'b0;
    pphase   = r4.pp_zero ? 32'd0 : r4.st.previous_phase_error;
    pdelay   = r4.pd_zero ? 32'd0 : r4.st.previous_delay_error;
    d        = (r4.e - pphase) + r4.ae;
    dd       = (r4.tau - pdelay) + r4.at;
    td       = d + 32'd16384;
    tdd      = dd + 32'd524288;
    sd       = $signed(td) >>> 15;
    sdd      = $signed(tdd) >>> 20;
    s.previous_phase_error = pphase;
    s.previous_delay_error = pdelay;
    if (r4.action) begin
      s = init_state(cfg);
    end else begin
      if (s.lock_bits[LK_CODE]) begin
        s.previous_phase_error = r4.e;
        s.carrier_nco_word     = r4.st.carrier_nco_word + r4.af - sd;
        s.previous_delay_error = r4.tau;
        s.code_nco_word        = r4.st.code_nco_word + sdd;
      end else begin
        slew = 1'b1;
        if (r4.over) begin
          s.half_chip_count  = '0;
          released           = r4.rel;
          s.frequency_bin    = r4.bn;
          s.code_nco_word    = cfg.code_reference + r4.code_off;
          s.carrier_nco_word = cfg.carrier_reference + r4.carr_off;
        end else begin
          s.half_chip_count = r4.h;
        end
      end
      s.previous_i_prompt = r4.ip;
      s.previous_q_prompt = r4.qp;
    end
    wr_data                = s;
    res.out_channel        = r4.chan;
    res.carrier_word       = s.carrier_nco_word;
    res.code_word          = s.code_nco_word;
    res.code_locked        = s.lock_bits[LK_CODE];
    res.carrier_locked     = s.lock_bits[LK_CARR];
    res.phase_locked       = s.lock_bits[LK_PHASE];
    res.slew_request       = slew;
    res.released           = released;
    res.average_code_power = $signed(s.code_power_avg);
  end

  assign wr_en     = v4;
  assign wr_addr   = ADDR_W'(r4.chan);
  assign res_valid = v4;

endmodule
`default_nettype wire

### hdl/gps_carrier_code_tracking_loop_core.sv
// Top level of the per-channel carrier and code tracking loop core.
`default_nettype none
`include "gps_carrier_code_tracking_loop_core_defines.svh"
// Each request carries one channel's correlator sums (or a restart) and yields
// one result with the new NCO words, lock flags and averaged code power.
// Channel state lives in a memory read at acceptance and written back by a
// four-stage pipeline, so requests for different channels are taken one per
// cycle while the result queue has room. A request for a channel still in the
// pipeline waits until its write-back. An 8-entry result queue decouples the
// output so input keeps flowing while a result waits, until requests in flight
// and queued results fill its slots. Requests for channels at or above
// NUM_CHANNELS are taken and dropped.
module gps_carrier_code_tracking_loop_core #(
  parameter int NUM_CHANNELS     = 16,
  parameter int CODE_SEARCH_SPAN = 2045
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  gcctl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output gcctl_pkg::out_item_t out_data,
  input  wire logic            cfg_write,
  input  wire logic [2:0]      cfg_addr,
  input  wire logic [31:0]     cfg_data
);
  import gcctl_pkg::*;

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cfg_t                  cfg;
  chan_state_t           rd_data, wr_data;
  logic                  wr_en, conflict, res_valid, start, in_ok, pop;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  out_item_t             res;
  out_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_count, fifo_count_next, occupancy, occupancy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_ACQUIRE_THRESHOLD:   cfg.acquire_threshold   <= cfg_data;
        REG_LOSS_THRESHOLD:      cfg.loss_threshold      <= cfg_data;
        REG_PULL_IN_LIMIT:       cfg.pull_in_limit       <= cfg_data[11:0];
        REG_SEARCH_WIDTH:        cfg.search_width        <= cfg_data[4:0];
        REG_CODE_REFERENCE:      cfg.code_reference      <= cfg_data;
        REG_CARRIER_REFERENCE:   cfg.carrier_reference   <= cfg_data;
        REG_CODE_SEARCH_STEP:    cfg.code_search_step    <= cfg_data[15:0];
        REG_CARRIER_SEARCH_STEP: cfg.carrier_search_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Occupancy counts requests in the pipeline plus results queued, so every
  // accepted request is sure of a queue slot.
  assign in_ok    = {28'd0, in_data.channel} < 32'(NUM_CHANNELS);
  assign in_ready = (occupancy < FIFO_CNT_W'(FIFO_DEPTH)) && !conflict;
  assign start    = in_valid && in_ready && in_ok;
  assign rd_addr  = ADDR_W'(in_data.channel);
  assign out_valid = fifo_count != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_mem[rd_ptr];

  assign fifo_count_next = fifo_count + FIFO_CNT_W'(res_valid) - FIFO_CNT_W'(pop);
  assign occupancy_next  = occupancy + FIFO_CNT_W'(start) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      occupancy  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count_next;
      occupancy  <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  gcctl_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (start),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gcctl_loop #(
    .NUM_CHANNELS     (NUM_CHANNELS),
    .CODE_SEARCH_SPAN (CODE_SEARCH_SPAN)
  ) u_loop (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (in_data),
    .cfg           (cfg),
    .rd_data       (rd_data),
    .probe_channel (in_data.channel),
    .conflict      (conflict),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .res_valid     (res_valid),
    .res           (res)
  );

  `GCCTL_ASSERT_CLK(a_occupancy_bound, occupancy <= FIFO_CNT_W'(FIFO_DEPTH), "occupancy overflow")
  `GCCTL_ASSERT_CLK(a_queue_within_occupancy, fifo_count <= occupancy, "queue exceeds occupancy")
  `GCCTL_ASSERT_CLK(a_no_read_during_write, (wr_en && start) |-> (wr_addr != rd_addr), "state hazard")
  `GCCTL_ASSERT_ALWAYS(a_reset_empty, rst |=> (occupancy == '0) && !out_valid, "not empty after reset")

endmodule
`default_nettype wire
